>>> hw/rtl/dqbs_pkg.sv
package dqbs_pkg;

   // operation codes carried in the mode field
   localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
   localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
   localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
   localparam logic [2:0] MODE_POP_BACK   = 3'd3;
   localparam logic [2:0] MODE_CONTAINS   = 3'd4;
   localparam logic [2:0] MODE_REMOVE     = 3'd5;

   // status codes of a result word
   localparam logic [1:0] STATUS_DONE       = 2'd0;
   localparam logic [1:0] STATUS_POP_EMPTY  = 2'd1;
   localparam logic [1:0] STATUS_PUSH_FULL  = 2'd2;

   localparam int unsigned DATA_W  = 32;
   localparam int unsigned COUNT_W = 5;

   typedef struct packed {
      logic [2:0]               mode;
      logic signed [DATA_W-1:0] item_value;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic                     found;
      logic signed [DATA_W-1:0] front_value;
      logic signed [DATA_W-1:0] back_value;
      logic [COUNT_W-1:0]       entry_count;
      logic                     is_empty;
   } rsp_type;

endpackage

>>> hw/rtl/dqbs_ram.sv
module dqbs_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/dqbs_slot.sv
module dqbs_slot #(
   parameter int unsigned DEPTH = 16
) (
   input  logic [$clog2(DEPTH)-1:0] head,
   input  logic [$clog2(DEPTH)-1:0] offset,
   output logic [$clog2(DEPTH)-1:0] slot
);

   localparam int unsigned IDX_W = $clog2(DEPTH);
   localparam logic [IDX_W:0] WRAP = (IDX_W+1)'(DEPTH);

   logic [IDX_W:0] sum;
   logic [IDX_W:0] wrapped;

   // ring position: (head + offset) mod DEPTH, both operands below DEPTH
   always_comb begin
      sum     = {1'b0, head} + {1'b0, offset};
      wrapped = (sum >= WRAP) ? (sum - WRAP) : sum;
      slot    = wrapped[IDX_W-1:0];
   end

endmodule

>>> hw/rtl/deque_with_bag_search_core.sv
// Bounded double-ended queue with value search, stored in one RAM ring.
// Input channel: drive req_data and raise start; the word is taken at a
// rising edge where start is high and busy is low. busy stays high while the
// operation runs. Modes: push front/back, pop front/back, contains, remove
// first match (later entries slide forward to close the gap).
// Result channel: rsp_data is valid for one cycle with rsp_strobe high, one
// result per input word; the receiver cannot stall and must take it then.
// Steps: after the accept edge an execute step does the push or pop; then
// the front and back entries are fetched in turn, and the result word is
// registered out with the strobe. contains adds a read and a compare step
// per entry scanned; remove scans the same way and, on a match, adds a read
// and a write step per later entry slid forward. A word other than a push
// that finds the store empty, or one that leaves it empty, skips the
// front/back fetch. Every ring access goes through one shared slot adder and
// the single RAM read port, whose read is registered, hence the separate
// read and compare or write steps. busy drops in the strobe cycle, so a new
// word is taken only once the last one is through.
// Reset (synchronous, active high) empties the queue; RAM contents are not
// cleared, only live entries are ever read.
module deque_with_bag_search_core #(
   parameter int unsigned DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  dqbs_pkg::req_type req_data,
   output logic              busy,
   output logic              rsp_strobe,
   output dqbs_pkg::rsp_type rsp_data
);

   localparam int unsigned IDX_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam int unsigned DW    = dqbs_pkg::DATA_W;
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
   localparam logic [IDX_W-1:0] BACK_STEP = IDX_W'(DEPTH - 1);
   localparam logic [IDX_W-1:0] ONE_STEP = IDX_W'(1);

   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_EXEC     = 9'b000000010,
      ST_SCAN_RD  = 9'b000000100,
      ST_SCAN_CMP = 9'b000001000,
      ST_SHIFT_RD = 9'b000010000,
      ST_SHIFT_WR = 9'b000100000,
      ST_FRONT_RD = 9'b001000000,
      ST_BACK_RD  = 9'b010000000,
      ST_RESP     = 9'b100000000
   } state_type;

   state_type           state_ff, state_in;
   logic [2:0]          mode_ff, mode_in;
   logic [DW-1:0]       value_ff, value_in;
   logic [IDX_W-1:0]    head_ff, head_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic [1:0]          status_ff, status_in;
   logic                found_ff, found_in;
   logic [DW-1:0]       front_ff, front_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   dqbs_pkg::rsp_type   rsp_ff, rsp_in;

   logic [IDX_W-1:0]    slot_offset;
   logic [IDX_W-1:0]    slot;
   logic                wr_en;
   logic [DW-1:0]       wr_data;
   logic [DW-1:0]       rd_data;
   logic [CNT_W-1:0]    count_less1;
   logic [CNT_W-1:0]    idx_plus1;
   logic [CNT_W:0]      idx_plus2;
   logic                is_full;
   logic                is_zero;
   logic [CNT_W+4:0]    count_ext;

   assign count_less1 = count_ff - CNT_W'(1);
   assign idx_plus1   = idx_ff + CNT_W'(1);
   assign idx_plus2   = {1'b0, idx_ff} + (CNT_W+1)'(2);
   assign is_full     = (count_ff == FULL_CNT);
   assign is_zero     = (count_ff == '0);
   assign count_ext   = {5'b0, count_ff};

   // offset fed to the shared slot adder, chosen by the sequencer step
   always_comb begin
      case (state_ff)
         ST_EXEC: begin
            case (mode_ff)
               dqbs_pkg::MODE_PUSH_FRONT: slot_offset = BACK_STEP;
               dqbs_pkg::MODE_PUSH_BACK:  slot_offset = count_ff[IDX_W-1:0];
               dqbs_pkg::MODE_POP_FRONT:  slot_offset = ONE_STEP;
               default:                   slot_offset = '0;
            endcase
         end
         ST_SCAN_RD:  slot_offset = idx_ff[IDX_W-1:0];
         ST_SHIFT_RD: slot_offset = idx_plus1[IDX_W-1:0];
         ST_SHIFT_WR: slot_offset = idx_ff[IDX_W-1:0];
         ST_BACK_RD:  slot_offset = count_less1[IDX_W-1:0];
         default:     slot_offset = '0;
      endcase
   end

   dqbs_slot #(
      .DEPTH (DEPTH)
   ) u_slot (
      .head   (head_ff),
      .offset (slot_offset),
      .slot   (slot)
   );

   dqbs_ram #(
      .WIDTH (DW),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot),
      .wr_data (wr_data),
      .rd_addr (slot),
      .rd_data (rd_data)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      value_in      = value_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      status_in     = status_ff;
      found_in      = found_ff;
      front_in      = front_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;
      wr_data       = value_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               mode_in   = req_data.mode;
               value_in  = req_data.item_value;
               status_in = dqbs_pkg::STATUS_DONE;
               found_in  = 1'b0;
               idx_in    = '0;
               state_in  = ST_EXEC;
            end
         end

         ST_EXEC: begin
            state_in = is_zero ? ST_RESP : ST_FRONT_RD;
            case (mode_ff)
               dqbs_pkg::MODE_PUSH_FRONT: begin
                  if (is_full) begin
                     status_in = dqbs_pkg::STATUS_PUSH_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     head_in  = slot;
                     count_in = count_ff + CNT_W'(1);
                     state_in = ST_FRONT_RD;
                  end
               end
               dqbs_pkg::MODE_PUSH_BACK: begin
                  if (is_full) begin
                     status_in = dqbs_pkg::STATUS_PUSH_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                     state_in = ST_FRONT_RD;
                  end
               end
               dqbs_pkg::MODE_POP_FRONT: begin
                  if (is_zero) begin
                     status_in = dqbs_pkg::STATUS_POP_EMPTY;
                  end else begin
                     head_in  = slot;
                     count_in = count_less1;
                     state_in = (count_less1 == '0) ? ST_RESP : ST_FRONT_RD;
                  end
               end
               dqbs_pkg::MODE_POP_BACK: begin
                  if (is_zero) begin
                     status_in = dqbs_pkg::STATUS_POP_EMPTY;
                  end else begin
                     count_in = count_less1;
                     state_in = (count_less1 == '0) ? ST_RESP : ST_FRONT_RD;
                  end
               end
               dqbs_pkg::MODE_CONTAINS, dqbs_pkg::MODE_REMOVE: begin
                  if (!is_zero) begin
                     state_in = ST_SCAN_RD;
                  end
               end
               default: begin
               end
            endcase
         end

         // read entry idx, compare it next cycle
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CMP;
         end

         ST_SCAN_CMP: begin
            if (rd_data == value_ff) begin
               found_in = 1'b1;
               if (mode_ff == dqbs_pkg::MODE_REMOVE) begin
                  if (idx_plus1 < count_ff) begin
                     state_in = ST_SHIFT_RD;
                  end else begin
                     count_in = count_less1;
                     state_in = (count_less1 == '0) ? ST_RESP : ST_FRONT_RD;
                  end
               end else begin
                  state_in = ST_FRONT_RD;
               end
            end else if (idx_plus1 == count_ff) begin
               state_in = ST_FRONT_RD;
            end else begin
               idx_in   = idx_plus1;
               state_in = ST_SCAN_RD;
            end
         end

         // slide entry idx+1 down into idx
         ST_SHIFT_RD: begin
            state_in = ST_SHIFT_WR;
         end

         ST_SHIFT_WR: begin
            wr_en   = 1'b1;
            wr_data = rd_data;
            idx_in  = idx_plus1;
            if (idx_plus2 < {1'b0, count_ff}) begin
               state_in = ST_SHIFT_RD;
            end else begin
               count_in = count_less1;
               state_in = ST_FRONT_RD;
            end
         end

         // fetch front, then back, then report
         ST_FRONT_RD: begin
            state_in = ST_BACK_RD;
         end

         ST_BACK_RD: begin
            front_in = rd_data;
            state_in = ST_RESP;
         end

         ST_RESP: begin
            rsp_strobe_in        = 1'b1;
            rsp_in.status        = status_ff;
            rsp_in.found         = found_ff;
            rsp_in.front_value   = is_zero ? '0 : front_ff;
            rsp_in.back_value    = is_zero ? '0 : rd_data;
            rsp_in.entry_count   = count_ext[4:0];
            rsp_in.is_empty      = is_zero;
            state_in             = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // operation payload and result word
   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      value_ff  <= value_in;
      idx_ff    <= idx_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      front_ff  <= front_in;
      rsp_ff    <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

>>> tb/sv/tb.sv
module tb;

   localparam int unsigned DEQUE_DEPTH  = 16;
   localparam int unsigned RANDOM_WORDS = 1850;
   localparam int unsigned CYCLE_LIMIT  = 800_000;
   localparam int unsigned DRAIN_CYCLES = 48;
   localparam int unsigned MAX_REPORTS  = 10;

   // mode codes the block treats as no-ops
   localparam logic [2:0] MODE_UNUSED_6 = 3'd6;
   localparam logic [2:0] MODE_UNUSED_7 = 3'd7;

   // one row of the directed table; reps > 1 pushes value, value+1, ...
   typedef struct packed {
      logic [2:0]         mode;
      logic signed [31:0] value;
      logic [4:0]         reps;
      logic               typed;
      dqbs_pkg::rsp_type  rsp;
   } stim_row_type;

   localparam int unsigned DIRECTED_ROWS = 24;
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      // empty store: rejected pops, searches that miss, a no-op mode
      '{dqbs_pkg::MODE_POP_FRONT, 32'sd0, 5'd1, 1'b1,
        '{dqbs_pkg::STATUS_POP_EMPTY, 1'b0, 32'sd0, 32'sd0, 5'd0, 1'b1}},
      '{dqbs_pkg::MODE_POP_BACK, 32'sd0, 5'd1, 1'b1,
        '{dqbs_pkg::STATUS_POP_EMPTY, 1'b0, 32'sd0, 32'sd0, 5'd0, 1'b1}},
      '{dqbs_pkg::MODE_CONTAINS, 32'sd0, 5'd1, 1'b1,
        '{dqbs_pkg::STATUS_DONE, 1'b0, 32'sd0, 32'sd0, 5'd0, 1'b1}},
      '{dqbs_pkg::MODE_REMOVE, 32'sd0, 5'd1, 1'b1,
        '{dqbs_pkg::STATUS_DONE, 1'b0, 32'sd0, 32'sd0, 5'd0, 1'b1}},
      '{MODE_UNUSED_6, 32'sd0, 5'd1, 1'b1,
        '{dqbs_pkg::STATUS_DONE, 1'b0, 32'sd0, 32'sd0, 5'd0, 1'b1}},
      // extreme values at both ends; push front wraps the head
      '{dqbs_pkg::MODE_PUSH_BACK, 32'h7FFF_FFFF, 5'd1, 1'b1,
        '{dqbs_pkg::STATUS_DONE, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 5'd1, 1'b0}},
      '{dqbs_pkg::MODE_PUSH_FRONT, 32'h8000_0000, 5'd1, 1'b1,
        '{dqbs_pkg::STATUS_DONE, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 5'd2, 1'b0}},
      '{dqbs_pkg::MODE_CONTAINS, 32'h8000_0000, 5'd1, 1'b1,
        '{dqbs_pkg::STATUS_DONE, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 5'd2, 1'b0}},
      '{dqbs_pkg::MODE_CONTAINS, 32'hFFFF_FFFF, 5'd1, 1'b1,
        '{dqbs_pkg::STATUS_DONE, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 5'd2, 1'b0}},
      '{dqbs_pkg::MODE_PUSH_BACK, 32'hFFFF_FFFF, 5'd1, 1'b0, '0},
      '{dqbs_pkg::MODE_PUSH_FRONT, 32'sd0, 5'd1, 1'b0, '0},
      // fill up to one short of full, then a duplicate at the front
      '{dqbs_pkg::MODE_PUSH_BACK, 32'sd100, 5'd11, 1'b0, '0},
      '{dqbs_pkg::MODE_PUSH_FRONT, 32'h7FFF_FFFF, 5'd1, 1'b0, '0},
      // pushes on a full store are rejected
      '{dqbs_pkg::MODE_PUSH_BACK, 32'sd5, 5'd1, 1'b1,
        '{dqbs_pkg::STATUS_PUSH_FULL, 1'b0, 32'h7FFF_FFFF, 32'sd110, 5'd16, 1'b0}},
      '{dqbs_pkg::MODE_PUSH_FRONT, 32'sd5, 5'd1, 1'b1,
        '{dqbs_pkg::STATUS_PUSH_FULL, 1'b0, 32'h7FFF_FFFF, 32'sd110, 5'd16, 1'b0}},
      // removals: duplicate at front first, then its twin, back, middle
      '{dqbs_pkg::MODE_REMOVE, 32'h7FFF_FFFF, 5'd1, 1'b0, '0},
      '{dqbs_pkg::MODE_REMOVE, 32'h7FFF_FFFF, 5'd1, 1'b0, '0},
      '{dqbs_pkg::MODE_REMOVE, 32'sd110, 5'd1, 1'b0, '0},
      '{dqbs_pkg::MODE_REMOVE, 32'sd105, 5'd1, 1'b0, '0},
      '{dqbs_pkg::MODE_CONTAINS, 32'sd105, 5'd1, 1'b0, '0},
      '{MODE_UNUSED_7, 32'h5555_5555, 5'd1, 1'b0, '0},
      '{dqbs_pkg::MODE_POP_FRONT, 32'sd0, 5'd1, 1'b0, '0},
      '{dqbs_pkg::MODE_POP_BACK, 32'sd0, 5'd1, 1'b0, '0},
      '{dqbs_pkg::MODE_REMOVE, 32'sd1234, 5'd1, 1'b0, '0}
   };

   logic              clock;
   logic              reset;
   logic              start;
   dqbs_pkg::req_type req_data;
   logic              busy;
   logic              rsp_strobe;
   dqbs_pkg::rsp_type rsp_data;

   // predictor state: live entries, front first
   logic signed [31:0] live_entries [$];
   dqbs_pkg::rsp_type  expected_words [$];

   int unsigned cycle_count;
   int unsigned mismatch_count;
   int unsigned words_sent;
   int unsigned words_checked;
   int unsigned full_rejects;
   int unsigned empty_rejects;
   int unsigned search_hits;
   int unsigned removals;

   deque_with_bag_search_core #(.DEPTH(DEQUE_DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_data   (req_data),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // apply one word to the predicted deque and return the expected result
   function automatic dqbs_pkg::rsp_type deque_apply(input dqbs_pkg::req_type w);
      dqbs_pkg::rsp_type r;
      int                hit;
      r   = '0;
      hit = -1;
      r.status = dqbs_pkg::STATUS_DONE;
      case (w.mode)
         dqbs_pkg::MODE_PUSH_FRONT, dqbs_pkg::MODE_PUSH_BACK: begin
            if (live_entries.size() >= DEQUE_DEPTH) begin
               r.status = dqbs_pkg::STATUS_PUSH_FULL;
               full_rejects++;
            end else if (w.mode == dqbs_pkg::MODE_PUSH_FRONT) begin
               live_entries.push_front(w.item_value);
            end else begin
               live_entries.push_back(w.item_value);
            end
         end
         dqbs_pkg::MODE_POP_FRONT, dqbs_pkg::MODE_POP_BACK: begin
            if (live_entries.size() == 0) begin
               r.status = dqbs_pkg::STATUS_POP_EMPTY;
               empty_rejects++;
            end else if (w.mode == dqbs_pkg::MODE_POP_FRONT) begin
               void'(live_entries.pop_front());
            end else begin
               void'(live_entries.pop_back());
            end
         end
         dqbs_pkg::MODE_CONTAINS, dqbs_pkg::MODE_REMOVE: begin
            // first match counted from the front
            for (int i = 0; i < live_entries.size(); i++)
               if (hit < 0 && live_entries[i] == w.item_value) hit = i;
            if (hit >= 0) begin
               r.found = 1'b1;
               search_hits++;
               if (w.mode == dqbs_pkg::MODE_REMOVE) begin
                  live_entries.delete(hit);
                  removals++;
               end
            end
         end
         default: ;
      endcase
      r.entry_count = 5'(live_entries.size());
      r.is_empty    = (live_entries.size() == 0);
      if (live_entries.size() != 0) begin
         r.front_value = live_entries[0];
         r.back_value  = live_entries[live_entries.size() - 1];
      end
      return r;
   endfunction

   // hold start with the word until it is taken, then record the expectation
   task automatic send_word(input dqbs_pkg::req_type w, input int unsigned gap,
                            input logic typed, input dqbs_pkg::rsp_type typed_rsp);
      dqbs_pkg::rsp_type predicted;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (busy !== 1'b0);
      predicted = deque_apply(w);
      expected_words.push_back(typed ? typed_rsp : predicted);
      words_sent++;
   endtask

   // value pool: small values so searches hit, extremes, full range, live copies
   function automatic logic signed [31:0] pick_value();
      logic signed [31:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = $signed($urandom_range(0, 7)) - 4;
         4, 5:       v = $urandom;
         6: begin
            case ($urandom_range(0, 3))
               0:       v = 32'h8000_0000;
               1:       v = 32'h7FFF_FFFF;
               2:       v = 32'hFFFF_FFFF;
               default: v = 32'h0000_0000;
            endcase
         end
         default: begin
            if (live_entries.size() != 0)
               v = live_entries[$urandom_range(0, live_entries.size() - 1)];
            else
               v = $urandom;
         end
      endcase
      return v;
   endfunction

   // mode mix per phase: fill, drain, balanced, search heavy
   function automatic logic [2:0] pick_mode(input int unsigned bias);
      int unsigned push_w;
      int unsigned pop_w;
      int unsigned r;
      case (bias)
         0:       begin push_w = 70; pop_w = 10; end
         1:       begin push_w = 20; pop_w = 60; end
         2:       begin push_w = 40; pop_w = 35; end
         default: begin push_w = 20; pop_w = 20; end
      endcase
      r = $urandom_range(0, 99);
      if (r < push_w)
         return $urandom_range(0, 1) ? dqbs_pkg::MODE_PUSH_FRONT : dqbs_pkg::MODE_PUSH_BACK;
      if (r < push_w + pop_w)
         return $urandom_range(0, 1) ? dqbs_pkg::MODE_POP_FRONT : dqbs_pkg::MODE_POP_BACK;
      if (r < 97)
         return $urandom_range(0, 1) ? dqbs_pkg::MODE_CONTAINS : dqbs_pkg::MODE_REMOVE;
      return $urandom_range(0, 1) ? MODE_UNUSED_6 : MODE_UNUSED_7;
   endfunction

   // result checker: every strobe must match the oldest expectation
   always @(posedge clock) begin
      dqbs_pkg::rsp_type exp_word;
      if (!reset && rsp_strobe === 1'b1) begin
         if (expected_words.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected result word at cycle %0d: %p", cycle_count, rsp_data);
         end else begin
            exp_word = expected_words.pop_front();
            words_checked++;
            if (rsp_data.status !== exp_word.status
                || rsp_data.found !== exp_word.found
                || rsp_data.front_value !== exp_word.front_value
                || rsp_data.back_value !== exp_word.back_value
                || rsp_data.entry_count !== exp_word.entry_count
                || rsp_data.is_empty !== exp_word.is_empty) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("word %0d mismatch at cycle %0d", words_checked, cycle_count);
                  $display("  expected status=%0d found=%0d front=%0d back=%0d count=%0d empty=%0d",
                           exp_word.status, exp_word.found, exp_word.front_value,
                           exp_word.back_value, exp_word.entry_count, exp_word.is_empty);
                  $display("  actual   status=%0d found=%0d front=%0d back=%0d count=%0d empty=%0d",
                           rsp_data.status, rsp_data.found, rsp_data.front_value,
                           rsp_data.back_value, rsp_data.entry_count, rsp_data.is_empty);
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding",
                  cycle_count, expected_words.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      dqbs_pkg::req_type w;
      int unsigned       sent_random;
      int unsigned       phase_len;
      int unsigned       bias;
      logic              burst;
      reset    <= 1'b1;
      start    <= 1'b0;
      req_data <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int row = 0; row < DIRECTED_ROWS; row++) begin
         for (int k = 0; k < DIRECTED[row].reps; k++) begin
            w.mode       = DIRECTED[row].mode;
            w.item_value = DIRECTED[row].value + k;
            send_word(w, $urandom_range(0, 17), DIRECTED[row].typed, DIRECTED[row].rsp);
         end
      end

      // random phases, each with its own mode mix and idling behavior
      sent_random = 0;
      while (sent_random < RANDOM_WORDS) begin
         phase_len = $urandom_range(20, 80);
         bias      = $urandom_range(0, 3);
         burst     = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < phase_len && sent_random < RANDOM_WORDS; k++) begin
            w.mode       = pick_mode(bias);
            w.item_value = pick_value();
            send_word(w, burst ? 0 : $urandom_range(0, 17), 1'b0, '0);
            sent_random++;
         end
      end
      start <= 1'b0;

      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d words checked: %0d full-store rejects, %0d empty-store rejects",
               words_checked, full_rejects, empty_rejects);
      $display("%0d search hits, %0d of them removals", search_hits, removals);
      if (mismatch_count == 0 && expected_words.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
